// ===== hw/rtl/fdp_pkg.sv =====
// ----------------------------------------------------------------------------
// fdp_pkg
// Shared types, codes and tables of the FAT directory entry parser.
// ----------------------------------------------------------------------------
package fdp_pkg;

    localparam int ENTRY_BYTES      = 32;
    localparam int ENTRY_AW         = 5;
    localparam int NAME_MAX_DEFAULT = 64;
    localparam int NAME_AW_MAX      = 6;
    localparam int LFN_CHARS        = 13;
    localparam int FPOS_W           = 9;

    // input op codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_NEW_DIR = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_END  = 2'd0;
    localparam logic [1:0] KIND_FILE = 2'd1;
    localparam logic [1:0] KIND_DIR  = 2'd2;

    // entry byte offsets
    localparam logic [ENTRY_AW-1:0] OFS_FIRST   = 5'd0;
    localparam logic [ENTRY_AW-1:0] OFS_EXT     = 5'd8;
    localparam logic [ENTRY_AW-1:0] OFS_BASE_END = 5'd7;
    localparam logic [ENTRY_AW-1:0] OFS_EXT_END = 5'd10;
    localparam logic [ENTRY_AW-1:0] OFS_ATTR    = 5'd11;
    localparam logic [ENTRY_AW-1:0] OFS_CLUS_HI = 5'd20;
    localparam logic [ENTRY_AW-1:0] OFS_CLUS_LO = 5'd26;
    localparam logic [ENTRY_AW-1:0] OFS_SIZE    = 5'd28;

    // byte values
    localparam logic [7:0] BYTE_END      = 8'h00;
    localparam logic [7:0] BYTE_DELETED  = 8'hE5;
    localparam logic [7:0] BYTE_ESC_E5   = 8'h05;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_PRINT_HI   = 8'h7E;
    localparam logic [7:0] ATTR_LFN_MASK = 8'h3F;
    localparam logic [7:0] ATTR_LFN      = 8'h0F;
    localparam int         ATTR_VOLUME_BIT = 3;
    localparam int         ATTR_DIR_BIT    = 4;
    localparam logic [7:0] SEQ_MASK      = 8'h1F;
    localparam int         SEQ_FIRST_BIT = 6;
    localparam logic [15:0] UCS_NONE     = 16'hFFFF;

    typedef struct packed {
        logic                we;
        logic [ENTRY_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic                re;
        logic [ENTRY_AW-1:0] raddr_a;
        logic [ENTRY_AW-1:0] raddr_b;
    } entry_req_t;

    typedef struct packed {
        logic                   we;
        logic [NAME_AW_MAX-1:0] waddr;
        logic [7:0]             wdata;
        logic                   re;
        logic [NAME_AW_MAX-1:0] raddr;
        logic                   clr_all;
        logic                   clr_first;
    } name_req_t;

    // byte offset of the low half of each long-name character
    function automatic logic [ENTRY_AW-1:0] frag_offset(input logic [3:0] idx);
        logic [ENTRY_AW-1:0] ofs;
        case (idx)
            4'd0:    ofs = 5'd1;
            4'd1:    ofs = 5'd3;
            4'd2:    ofs = 5'd5;
            4'd3:    ofs = 5'd7;
            4'd4:    ofs = 5'd9;
            4'd5:    ofs = 5'd14;
            4'd6:    ofs = 5'd16;
            4'd7:    ofs = 5'd18;
            4'd8:    ofs = 5'd20;
            4'd9:    ofs = 5'd22;
            4'd10:   ofs = 5'd24;
            4'd11:   ofs = 5'd28;
            4'd12:   ofs = 5'd30;
            default: ofs = 5'd1;
        endcase
        return ofs;
    endfunction

endpackage

// ===== hw/rtl/fdp_entry_buf.sv =====
// ----------------------------------------------------------------------------
// fdp_entry_buf
// 32-byte entry memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fdp_entry_buf (
    input  logic               clk,
    input  fdp_pkg::entry_req_t req,
    output logic [7:0]         rd_a,
    output logic [7:0]         rd_b
);
    import fdp_pkg::*;

    logic [7:0] mem [ENTRY_BYTES];
    logic [7:0] rd_a_reg;
    logic [7:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_a_reg <= mem[req.raddr_a];
            rd_b_reg <= mem[req.raddr_b];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

// ===== hw/rtl/fdp_name_store.sv =====
// ----------------------------------------------------------------------------
// fdp_name_store
// Long-name character memory with a valid bit per position; an invalid
// position reads as zero, so clearing the store needs no pass over the memory.
// ----------------------------------------------------------------------------
module fdp_name_store #(
    parameter int NAME_MAX = fdp_pkg::NAME_MAX_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fdp_pkg::name_req_t req,
    output logic [7:0]        rd_char
);
    import fdp_pkg::*;

    localparam int LN_AW = $clog2(NAME_MAX);

    logic [7:0]          mem [NAME_MAX];
    logic [NAME_MAX-1:0] valid_reg;
    logic [NAME_MAX-1:0] valid_next;
    logic [7:0]          rd_data_reg;
    logic                rd_valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.clr_all)
        begin
            valid_next = '0;
        end
        else if (req.clr_first)
        begin
            valid_next[0] = 1'b0;
        end
        if (req.we)
        begin
            valid_next[req.waddr[LN_AW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.re)
            begin
                rd_valid_reg <= valid_reg[req.raddr[LN_AW-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[LN_AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr[LN_AW-1:0]];
        end
    end

    assign rd_char = rd_valid_reg ? rd_data_reg : 8'h00;

endmodule

// ===== hw/rtl/fdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdp_ctrl
// Entry sequencer: collects bytes, classifies each entry, merges long-name
// fragments into the name store and emits name characters.
// ----------------------------------------------------------------------------
module fdp_ctrl #(
    parameter int NAME_MAX = fdp_pkg::NAME_MAX_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [7:0]         name_char,
    output logic               name_is_long,
    output logic [27:0]        first_cluster,
    output logic [31:0]        file_size,
    output logic [7:0]         attributes,
    output logic               last,
    output fdp_pkg::entry_req_t entry_req,
    input  logic [7:0]         entry_rd_a,
    input  logic [7:0]         entry_rd_b,
    output fdp_pkg::name_req_t  name_req,
    input  logic [7:0]         name_rd
);
    import fdp_pkg::*;

    localparam int LN_AW = $clog2(NAME_MAX);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_FRD    = 8'b0000_0100,
        S_FWR    = 8'b0000_1000,
        S_ERD    = 8'b0001_0000,
        S_EEV    = 8'b0010_0000,
        S_EDOT   = 8'b0100_0000,
        S_EEND   = 8'b1000_0000
    } state_t;

    typedef enum logic [3:0] {
        M_LCHK = 4'b0001,
        M_LONG = 4'b0010,
        M_BASE = 4'b0100,
        M_EXT  = 4'b1000
    } mode_t;

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [ENTRY_AW-1:0] pos_reg, pos_next;
    logic                done_reg, done_next;
    logic                fat32_reg;
    logic [3:0]          fidx_reg, fidx_next;
    logic [FPOS_W-1:0]   fpos_reg, fpos_next;
    logic [ENTRY_AW-1:0] eidx_reg, eidx_next;
    logic [LN_AW-1:0]    lidx_reg, lidx_next;
    logic                is_long_reg, is_long_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [7:0]          pend_char_reg, pend_char_next;

    // entry header, captured as the bytes stream past
    logic [7:0]  b0_reg;
    logic [7:0]  b8_reg;
    logic [7:0]  attr_reg;
    logic [15:0] clus_hi_reg;
    logic [15:0] clus_lo_reg;
    logic [31:0] size_reg;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg;
    logic [7:0]  out_char_reg;
    logic        out_long_reg;
    logic [27:0] out_clus_reg;
    logic [31:0] out_size_reg;
    logic [7:0]  out_attr_reg;
    logic        out_last_reg;

    logic        in_xfer;
    logic        byte_take;
    logic        out_free;
    logic        ev_char_en;
    logic [7:0]  ev_char;
    logic        ev_end_en;
    logic        ev_stall;
    logic        push;
    logic        push_eod;
    logic [7:0]  push_char;
    logic        push_last;
    logic [4:0]  seq;
    logic [15:0] ucs;
    logic [7:0]  lfn_char;
    logic [27:0] entry_clus;
    logic [1:0]  entry_kind;
    logic        ext_present;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign byte_take = in_xfer && (op == OP_BYTE) && !done_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign seq         = b0_reg[4:0] & SEQ_MASK[4:0];
    assign ucs         = {entry_rd_b, entry_rd_a};
    assign entry_clus  = {(fat32_reg ? clus_hi_reg[11:0] : 12'h000), clus_lo_reg};
    assign entry_kind  = attr_reg[ATTR_DIR_BIT] ? KIND_DIR : KIND_FILE;
    assign ext_present = (b8_reg != CH_SPACE);

    // fold a UCS-2 fragment character onto the stored byte
    always_comb
    begin
        if ((ucs == 16'h0000) || (ucs == UCS_NONE))
        begin
            lfn_char = 8'h00;
        end
        else if ((ucs > {8'h00, CH_PRINT_HI}) || (ucs < {8'h00, CH_SPACE}))
        begin
            lfn_char = CH_UNDERSCORE;
        end
        else
        begin
            lfn_char = ucs[7:0];
        end
    end

    // name character source for the current emission step
    always_comb
    begin
        ev_char_en = 1'b0;
        ev_char    = 8'h00;
        ev_end_en  = 1'b0;
        case (state_reg)
            S_EEV:
            begin
                case (mode_reg)
                    M_LONG:
                    begin
                        ev_char_en = (name_rd != 8'h00);
                        ev_char    = name_rd;
                    end
                    M_BASE:
                    begin
                        ev_char_en = (entry_rd_a != CH_SPACE);
                        if ((eidx_reg == OFS_FIRST) && (entry_rd_a == BYTE_ESC_E5))
                        begin
                            ev_char = BYTE_DELETED;
                        end
                        else
                        begin
                            ev_char = entry_rd_a;
                        end
                    end
                    M_EXT:
                    begin
                        ev_char_en = (entry_rd_a != CH_SPACE);
                        ev_char    = entry_rd_a;
                    end
                    default:
                    begin
                        ev_char_en = 1'b0;
                    end
                endcase
            end
            S_EDOT:
            begin
                ev_char_en = 1'b1;
                ev_char    = CH_DOT;
            end
            S_EEND:
            begin
                ev_end_en = 1'b1;
            end
            default:
            begin
                ev_end_en = 1'b0;
            end
        endcase
    end

    // hold while a character or the end of a name needs the output register and it is still full
    assign ev_stall = (ev_char_en && pend_valid_reg && !out_free) || (ev_end_en && !out_free);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        done_next       = done_reg;
        fidx_next       = fidx_reg;
        fpos_next       = fpos_reg;
        eidx_next       = eidx_reg;
        lidx_next       = lidx_reg;
        is_long_next    = is_long_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        push            = 1'b0;
        push_eod        = 1'b0;
        push_char       = 8'h00;
        push_last       = 1'b0;
        entry_req       = '0;
        name_req        = '0;

        // one name character behind the source, so last is known on transfer
        if (ev_char_en && !ev_stall)
        begin
            push            = pend_valid_reg;
            push_char       = pend_char_reg;
            pend_valid_next = 1'b1;
            pend_char_next  = ev_char;
        end
        if (ev_end_en && !ev_stall)
        begin
            push            = 1'b1;
            push_char       = pend_valid_reg ? pend_char_reg : 8'h00;
            push_last       = 1'b1;
            pend_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (op == OP_NEW_DIR))
                begin
                    pos_next           = '0;
                    done_next          = 1'b0;
                    name_req.clr_first = 1'b1;
                end
                else if (byte_take)
                begin
                    entry_req.we    = 1'b1;
                    entry_req.waddr = pos_reg;
                    entry_req.wdata = data_byte;
                    pos_next        = pos_reg + 1'b1;
                    if (pos_reg == ENTRY_AW'(ENTRY_BYTES - 1))
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                if (b0_reg == BYTE_END)
                begin
                    if (out_free)
                    begin
                        push       = 1'b1;
                        push_eod   = 1'b1;
                        push_last  = 1'b1;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (b0_reg == BYTE_DELETED)
                begin
                    name_req.clr_first = 1'b1;
                    state_next         = S_IDLE;
                end
                else if ((attr_reg & ATTR_LFN_MASK) == ATTR_LFN)
                begin
                    name_req.clr_all = b0_reg[SEQ_FIRST_BIT];
                    fidx_next        = 4'd0;
                    fpos_next        = FPOS_W'(seq - 5'd1) * FPOS_W'(LFN_CHARS);
                    // sequence zero writes nothing
                    state_next       = (seq == 5'd0) ? S_IDLE : S_FRD;
                end
                else if (attr_reg[ATTR_VOLUME_BIT])
                begin
                    name_req.clr_first = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    mode_next  = M_LCHK;
                    state_next = S_ERD;
                end
            end
            S_FRD:
            begin
                entry_req.re      = 1'b1;
                entry_req.raddr_a = frag_offset(fidx_reg);
                entry_req.raddr_b = frag_offset(fidx_reg) + 1'b1;
                state_next        = S_FWR;
            end
            S_FWR:
            begin
                // positions beyond the store are dropped
                if (fpos_reg < FPOS_W'(NAME_MAX))
                begin
                    name_req.we    = 1'b1;
                    name_req.waddr = NAME_AW_MAX'(fpos_reg[LN_AW-1:0]);
                    name_req.wdata = lfn_char;
                end
                fidx_next = fidx_reg + 1'b1;
                fpos_next = fpos_reg + 1'b1;
                if (fidx_reg == 4'(LFN_CHARS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FRD;
                end
            end
            S_ERD:
            begin
                case (mode_reg)
                    M_LCHK:
                    begin
                        name_req.re    = 1'b1;
                        name_req.raddr = '0;
                    end
                    M_LONG:
                    begin
                        name_req.re    = 1'b1;
                        name_req.raddr = NAME_AW_MAX'(lidx_reg);
                    end
                    default:
                    begin
                        entry_req.re      = 1'b1;
                        entry_req.raddr_a = eidx_reg;
                        entry_req.raddr_b = eidx_reg;
                    end
                endcase
                state_next = S_EEV;
            end
            S_EEV:
            begin
                case (mode_reg)
                    M_LCHK:
                    begin
                        is_long_next = (name_rd != 8'h00);
                        mode_next    = (name_rd != 8'h00) ? M_LONG : M_BASE;
                        lidx_next    = '0;
                        eidx_next    = OFS_FIRST;
                        state_next   = S_ERD;
                    end
                    M_LONG:
                    begin
                        if (!ev_char_en)
                        begin
                            state_next = S_EEND;
                        end
                        else if (!ev_stall)
                        begin
                            lidx_next = lidx_reg + 1'b1;
                            if (lidx_reg == LN_AW'(NAME_MAX - 1))
                            begin
                                state_next = S_EEND;
                            end
                            else
                            begin
                                state_next = S_ERD;
                            end
                        end
                    end
                    M_BASE:
                    begin
                        if (!ev_char_en)
                        begin
                            state_next = ext_present ? S_EDOT : S_EEND;
                        end
                        else if (!ev_stall)
                        begin
                            eidx_next = eidx_reg + 1'b1;
                            if (eidx_reg == OFS_BASE_END)
                            begin
                                state_next = ext_present ? S_EDOT : S_EEND;
                            end
                            else
                            begin
                                state_next = S_ERD;
                            end
                        end
                    end
                    default:
                    begin
                        if (!ev_char_en)
                        begin
                            state_next = S_EEND;
                        end
                        else if (!ev_stall)
                        begin
                            eidx_next = eidx_reg + 1'b1;
                            if (eidx_reg == OFS_EXT_END)
                            begin
                                state_next = S_EEND;
                            end
                            else
                            begin
                                state_next = S_ERD;
                            end
                        end
                    end
                endcase
            end
            S_EDOT:
            begin
                if (!ev_stall)
                begin
                    mode_next  = M_EXT;
                    eidx_next  = OFS_EXT;
                    state_next = S_ERD;
                end
            end
            S_EEND:
            begin
                if (!ev_stall)
                begin
                    // a long name serves one entry only
                    name_req.clr_first = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_LCHK;
            pos_reg        <= '0;
            done_reg       <= 1'b0;
            fat32_reg      <= 1'b0;
            fidx_reg       <= '0;
            fpos_reg       <= '0;
            eidx_reg       <= '0;
            lidx_reg       <= '0;
            is_long_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            done_reg       <= done_next;
            fidx_reg       <= fidx_next;
            fpos_reg       <= fpos_next;
            eidx_reg       <= eidx_next;
            lidx_reg       <= lidx_next;
            is_long_reg    <= is_long_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write)
            begin
                fat32_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_char_reg <= pend_char_next;
        if (byte_take)
        begin
            case (pos_reg)
                OFS_FIRST:              b0_reg            <= data_byte;
                OFS_EXT:                b8_reg            <= data_byte;
                OFS_ATTR:               attr_reg          <= data_byte;
                OFS_CLUS_HI:            clus_hi_reg[7:0]  <= data_byte;
                OFS_CLUS_HI + 5'd1:     clus_hi_reg[15:8] <= data_byte;
                OFS_CLUS_LO:            clus_lo_reg[7:0]  <= data_byte;
                OFS_CLUS_LO + 5'd1:     clus_lo_reg[15:8] <= data_byte;
                OFS_SIZE:               size_reg[7:0]     <= data_byte;
                OFS_SIZE + 5'd1:        size_reg[15:8]    <= data_byte;
                OFS_SIZE + 5'd2:        size_reg[23:16]   <= data_byte;
                OFS_SIZE + 5'd3:        size_reg[31:24]   <= data_byte;
                default:                b0_reg            <= b0_reg;
            endcase
        end
        if (push)
        begin
            out_char_reg <= push_char;
            out_last_reg <= push_last;
            if (push_eod)
            begin
                out_kind_reg <= KIND_END;
                out_long_reg <= 1'b0;
                out_clus_reg <= '0;
                out_size_reg <= '0;
                out_attr_reg <= 8'h00;
            end
            else
            begin
                out_kind_reg <= entry_kind;
                out_long_reg <= is_long_reg;
                out_clus_reg <= entry_clus;
                out_size_reg <= size_reg;
                out_attr_reg <= attr_reg;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign name_char     = out_char_reg;
    assign name_is_long  = out_long_reg;
    assign first_cluster = out_clus_reg;
    assign file_size     = out_size_reg;
    assign attributes    = out_attr_reg;
    assign last          = out_last_reg;

    // the entry memory is only written while collecting bytes
    a_entry_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        entry_req.we |-> (state_reg == S_IDLE) && !done_reg)
        else $error("entry memory written outside byte collection");

    // handling always starts from a wrapped byte position
    a_pos_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (pos_reg == '0))
        else $error("byte position not zero while handling an entry");

    a_name_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        name_req.we |-> (fpos_reg < FPOS_W'(NAME_MAX)))
        else $error("long-name write beyond the store");

    a_pend_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> ((state_reg == S_ERD) || (state_reg == S_EEV) ||
                            (state_reg == S_EDOT) || (state_reg == S_EEND)))
        else $error("pending name character outside emission");

    a_end_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DECIDE) && (b0_reg == BYTE_END) && out_free) |=> done_reg)
        else $error("end of directory not recorded");

endmodule

// ===== hw/rtl/fat_directory_entry_parser.sv =====
// ----------------------------------------------------------------------------
// fat_directory_entry_parser
// FAT directory entry parser with long file name support.
// ----------------------------------------------------------------------------
// Directory bytes are taken one per cycle; the 32nd byte of an entry starts
// its handling and input is held until that is done. Deleted entries, volume
// labels and the end marker are settled in the decision state alone (the end
// marker also waits for the output register). Each of the 13 characters of a
// long-name fragment is one read of the entry memory and one write to the
// name store. A file or subdirectory entry takes a check of the long-name
// store, then one memory read and one evaluation per name character, plus one
// for the dot and one for the end, and waits while the result side stalls.
// Results leave through an output register, so a result may wait while the
// next bytes are collected. The long-name store clears through per-position
// valid bits, so there is no clearing pass after reset.
module fat_directory_entry_parser #(
    parameter int NAME_MAX = fdp_pkg::NAME_MAX_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  name_char,
    output logic        name_is_long,
    output logic [27:0] first_cluster,
    output logic [31:0] file_size,
    output logic [7:0]  attributes,
    output logic        last
);
    import fdp_pkg::*;

    entry_req_t entry_req;
    name_req_t  name_req;
    logic [7:0] entry_rd_a;
    logic [7:0] entry_rd_b;
    logic [7:0] name_rd;

    fdp_entry_buf u_entry_buf (
        .clk  (clk),
        .req  (entry_req),
        .rd_a (entry_rd_a),
        .rd_b (entry_rd_b)
    );

    fdp_name_store #(
        .NAME_MAX (NAME_MAX)
    ) u_name_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (name_req),
        .rd_char (name_rd)
    );

    fdp_ctrl #(
        .NAME_MAX (NAME_MAX)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .name_char     (name_char),
        .name_is_long  (name_is_long),
        .first_cluster (first_cluster),
        .file_size     (file_size),
        .attributes    (attributes),
        .last          (last),
        .entry_req     (entry_req),
        .entry_rd_a    (entry_rd_a),
        .entry_rd_b    (entry_rd_b),
        .name_req      (name_req),
        .name_rd       (name_rd)
    );

endmodule
